// ----- sv/b64le_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 line encoder.
`default_nettype none

package b64le_pkg;

    localparam int LINE_BYTES_DEF = 48;
    localparam int CNT_W          = 6;
    localparam int MAX_RES        = 6;
    localparam int RES_IDX_W      = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIXED    = 2'd1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] NEWLINE  = 8'h0A;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_PREFIX = 2'd1,
        KIND_EOL    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0]   res;
        logic [RES_IDX_W-1:0] cnt;
    } t_plan;

    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            return v + 8'd65;
        end else if (six < 6'd52) begin
            return v + 8'd71;
        end else if (six < 6'd62) begin
            return v - 8'd4;
        end else if (six == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/b64le_front.sv -----
// Front end: accepts bytes, holds line and group state and builds the result list of each byte.
`default_nettype none

module b64le_front #(
    parameter int LINE_BYTES = b64le_pkg::LINE_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [b64le_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic                             i_cfg_data,
    input  wire logic                             i_valid,
    input  wire logic [7:0]                       i_byte,
    input  wire logic                             i_eof,
    output logic                                  o_ready,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output b64le_pkg::t_plan                      o_plan
);

    logic                              r_mode;
    logic                              r_pref;
    logic [1:0]                        r_phase;
    logic [3:0]                        r_held;
    logic [b64le_pkg::CNT_W-1:0]       r_cnt;

    logic [1:0]                        n_phase;
    logic [3:0]                        n_held;
    logic [b64le_pkg::CNT_W-1:0]       n_cnt;

    logic [b64le_pkg::CNT_W-1:0]       cnt_inc;
    logic                              line_end;
    logic [b64le_pkg::RES_IDX_W-1:0]   idx;
    b64le_pkg::t_plan                  plan;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_plan  = plan;

    always_comb begin
        cnt_inc  = r_cnt + 1'b1;
        line_end = i_eof || (cnt_inc >= b64le_pkg::CNT_W'(LINE_BYTES)) || (cnt_inc == '0);
        plan     = '0;
        idx      = '0;
        n_phase  = r_phase;
        n_held   = r_held;
        n_cnt    = cnt_inc;

        if (r_cnt == '0 && r_pref) begin
            plan.res[idx] = '{kind: b64le_pkg::KIND_PREFIX, code: 8'h00};
            idx = idx + 1'b1;
        end

        if (r_mode) begin
            n_phase = 2'd0;
            n_held  = 4'd0;
            plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR, code: i_byte};
            idx = idx + 1'b1;
            if (i_byte == b64le_pkg::NEWLINE && r_pref) begin
                plan.res[idx] = '{kind: b64le_pkg::KIND_PREFIX, code: 8'h00};
                idx = idx + 1'b1;
            end
        end else begin
            case (r_phase)
                2'd0: begin
                    plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                      code: b64le_pkg::b64_char(i_byte[7:2])};
                    idx = idx + 1'b1;
                    n_held  = {2'b00, i_byte[1:0]};
                    n_phase = 2'd1;
                    if (line_end) begin
                        plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                          code: b64le_pkg::b64_char({i_byte[1:0], 4'b0000})};
                        idx = idx + 1'b1;
                        plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR, code: b64le_pkg::PAD_CHAR};
                        idx = idx + 1'b1;
                        plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR, code: b64le_pkg::PAD_CHAR};
                        idx = idx + 1'b1;
                    end
                end
                2'd1: begin
                    plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                      code: b64le_pkg::b64_char({r_held[1:0], i_byte[7:4]})};
                    idx = idx + 1'b1;
                    n_held  = i_byte[3:0];
                    n_phase = 2'd2;
                    if (line_end) begin
                        plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                          code: b64le_pkg::b64_char({i_byte[3:0], 2'b00})};
                        idx = idx + 1'b1;
                        plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR, code: b64le_pkg::PAD_CHAR};
                        idx = idx + 1'b1;
                    end
                end
                default: begin
                    plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                      code: b64le_pkg::b64_char({r_held, i_byte[7:6]})};
                    idx = idx + 1'b1;
                    plan.res[idx] = '{kind: b64le_pkg::KIND_CHAR,
                                      code: b64le_pkg::b64_char(i_byte[5:0])};
                    idx = idx + 1'b1;
                    n_held  = 4'd0;
                    n_phase = 2'd0;
                end
            endcase
        end

        if (line_end) begin
            plan.res[idx] = '{kind: b64le_pkg::KIND_EOL, code: 8'h00};
            idx = idx + 1'b1;
            n_cnt   = '0;
            n_phase = 2'd0;
            n_held  = 4'd0;
        end

        plan.cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_pref  <= 1'b1;
            r_phase <= 2'd0;
            r_held  <= 4'd0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    b64le_pkg::CFG_OUTPUT_MODE: r_mode <= i_cfg_data;
                    b64le_pkg::CFG_PREFIXED:    r_pref <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/b64le_queue.sv -----
// Short queue of per-byte result lists between the front end and the output stage.
`default_nettype none

module b64le_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64le_pkg::t_plan  i_plan,
    input  wire logic              i_pop,
    output b64le_pkg::t_plan       o_head,
    output logic                   o_full,
    output logic                   o_empty
);

    b64le_pkg::t_plan                  r_mem [b64le_pkg::FIFO_DEPTH];
    logic [b64le_pkg::FIFO_PTR_W-1:0]  r_wr;
    logic [b64le_pkg::FIFO_PTR_W-1:0]  r_rd;
    logic [b64le_pkg::FIFO_PTR_W:0]    r_fill;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_fill == (b64le_pkg::FIFO_PTR_W+1)'(b64le_pkg::FIFO_DEPTH));
    assign o_empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/b64le_back.sv -----
// Back end: walks queued result lists, one result per cycle from an output register while i_ready.
`default_nettype none

module b64le_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64le_pkg::t_plan  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_code,
    output logic                   o_last
);

    logic                              r_valid;
    logic [1:0]                        r_kind;
    logic [7:0]                        r_code;
    logic                              r_last;
    logic [b64le_pkg::RES_IDX_W-1:0]   r_idx;

    logic                              adv;
    logic                              take;
    logic                              is_last;
    b64le_pkg::t_res                   cur;

    assign adv     = !r_valid || i_ready;
    assign take    = adv && !i_empty;
    assign cur     = i_head.res[r_idx];
    assign is_last = (r_idx == (i_head.cnt - 1'b1));
    assign o_pop   = take && is_last;

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_code  = r_code;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= cur.kind;
            r_code <= cur.code;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (adv) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/base64_line_encoder_unit.sv -----
// Top level of the base64 line encoder: front end, result-list queue and output stage.
// The plan of an accepted byte is written into the queue; its first result is then loaded into
// the output register. One byte per cycle while the four-entry queue has room, one result per
// cycle while the receiver is ready; a byte yields one to six results, one or two mid-line in
// base64 mode, and the single output register drains the queue.
// Reset is synchronous and active low: mode returns to base64, prefixing on, line and
// group state cleared, queue and output emptied.
`default_nettype none

module base64_line_encoder_unit #(
    parameter int LINE_BYTES = b64le_pkg::LINE_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [b64le_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic                             i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
    input  wire logic                             s_axis_tlast,   // end_of_file
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [7:0]                            m_axis_tdata,   // [7:0] char_code
    output logic [1:0]                            m_axis_tuser,   // [1:0] item_kind
    output logic                                  m_axis_tlast    // last_of_run
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    b64le_pkg::t_plan  plan;
    b64le_pkg::t_plan  head;

    assign o_cfg_ready = 1'b1;

    b64le_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_eof       (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_full      (full),
        .o_push      (push),
        .o_plan      (plan)
    );

    b64le_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (plan),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    b64le_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_code  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the base64 line encoder: directed table, random files, live predictor.
`timescale 1ns / 1ps

module tb;

    localparam logic [b64le_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [b64le_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int RANDOM_BYTES = 100;
    localparam int CALM_AFTER   = 85;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_op;

    typedef struct packed {
        b64le_pkg::t_kind kind;
        logic [7:0]       code;
        logic             last;
    } t_sym;

    typedef struct packed {
        t_row_op                         op;
        logic [b64le_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [7:0]                      val;
        logic                            flag;
        logic [2:0]                      n_typed;
    } t_dir_row;

    // Byte rows carry the data byte and the end-of-file mark; register rows carry the
    // register index and the written bit. A nonzero n_typed takes that many results
    // from the typed list instead of the predictor.
    localparam int N_DIR = 25;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_BYTE, '0,                         8'h00, 1'b1, 3'd6},
        '{ROW_BYTE, '0,                         8'hFF, 1'b1, 3'd6},
        '{ROW_BYTE, '0,                         8'h4D, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h61, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h6E, 1'b1, 3'd0},
        '{ROW_BYTE, '0,                         8'hFF, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h00, 1'b1, 3'd0},
        '{ROW_REG,  b64le_pkg::CFG_PREFIXED,    8'h00, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h12, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h34, 1'b0, 3'd0},
        '{ROW_REG,  b64le_pkg::CFG_OUTPUT_MODE, 8'h00, 1'b1, 3'd0},
        '{ROW_BYTE, '0,                         b64le_pkg::NEWLINE, 1'b0, 3'd1},
        '{ROW_BYTE, '0,                         8'h41, 1'b0, 3'd0},
        '{ROW_REG,  b64le_pkg::CFG_PREFIXED,    8'h00, 1'b1, 3'd0},
        '{ROW_BYTE, '0,                         b64le_pkg::NEWLINE, 1'b0, 3'd2},
        '{ROW_BYTE, '0,                         8'h7E, 1'b0, 3'd0},
        '{ROW_REG,  b64le_pkg::CFG_OUTPUT_MODE, 8'h00, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'h80, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         8'hC3, 1'b1, 3'd0},
        '{ROW_REG,  CFG_SPARE_LO,               8'h00, 1'b1, 3'd0},
        '{ROW_REG,  CFG_SPARE_HI,               8'h00, 1'b0, 3'd0},
        '{ROW_BYTE, '0,                         b64le_pkg::NEWLINE, 1'b1, 3'd0},
        '{ROW_REG,  b64le_pkg::CFG_OUTPUT_MODE, 8'h00, 1'b1, 3'd0},
        '{ROW_BYTE, '0,                         8'h00, 1'b1, 3'd3},
        '{ROW_BYTE, '0,                         8'hFF, 1'b1, 3'd0}
    };

    localparam int N_TYPED = 18;
    localparam t_sym TYPED_SYMS [N_TYPED] = '{
        '{b64le_pkg::KIND_PREFIX, 8'h00,              1'b0},
        '{b64le_pkg::KIND_CHAR,   "A",                1'b0},
        '{b64le_pkg::KIND_CHAR,   "A",                1'b0},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::PAD_CHAR, 1'b0},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::PAD_CHAR, 1'b0},
        '{b64le_pkg::KIND_EOL,    8'h00,              1'b1},
        '{b64le_pkg::KIND_PREFIX, 8'h00,              1'b0},
        '{b64le_pkg::KIND_CHAR,   "/",                1'b0},
        '{b64le_pkg::KIND_CHAR,   "w",                1'b0},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::PAD_CHAR, 1'b0},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::PAD_CHAR, 1'b0},
        '{b64le_pkg::KIND_EOL,    8'h00,              1'b1},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::NEWLINE, 1'b1},
        '{b64le_pkg::KIND_CHAR,   b64le_pkg::NEWLINE, 1'b0},
        '{b64le_pkg::KIND_PREFIX, 8'h00,              1'b1},
        '{b64le_pkg::KIND_PREFIX, 8'h00,              1'b0},
        '{b64le_pkg::KIND_CHAR,   8'h00,              1'b0},
        '{b64le_pkg::KIND_EOL,    8'h00,              1'b1}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [b64le_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic       i_cfg_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       o_cfg_ready;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    string B64_DIGITS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Predictor state and configuration.
    logic       txt_mode = 1'b0;
    logic       prefix_on = 1'b1;
    logic [1:0] grp_phase = 2'd0;
    logic [7:0] grp_bits = 8'h00;
    logic [5:0] line_cnt = 6'd0;

    t_sym byte_run[$];
    t_sym pending[$];
    int  typed_pos = 0;
    int  bytes_fed = 0;
    int  syms_checked = 0;
    int  mismatches = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    base64_line_encoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] sextet(input logic [5:0] s);
        return B64_DIGITS[s];
    endfunction

    function automatic void add_sym(input b64le_pkg::t_kind k, input logic [7:0] c);
        byte_run.push_back('{k, (k == b64le_pkg::KIND_CHAR) ? c : 8'h00, 1'b0});
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic eof);
        logic at_end;
        byte_run.delete();
        if (line_cnt == 6'd0 && prefix_on) add_sym(b64le_pkg::KIND_PREFIX, 8'h00);
        line_cnt = line_cnt + 6'd1;
        at_end = eof || (line_cnt >= b64le_pkg::LINE_BYTES_DEF) || (line_cnt == 6'd0);
        if (txt_mode) begin
            grp_phase = 2'd0;
            grp_bits = 8'h00;
            add_sym(b64le_pkg::KIND_CHAR, b);
            if (b == b64le_pkg::NEWLINE && prefix_on) add_sym(b64le_pkg::KIND_PREFIX, 8'h00);
        end else begin
            case (grp_phase)
                2'd0: begin
                    add_sym(b64le_pkg::KIND_CHAR, sextet(b[7:2]));
                    grp_bits = {6'd0, b[1:0]};
                    grp_phase = 2'd1;
                    if (at_end) begin
                        add_sym(b64le_pkg::KIND_CHAR, sextet({b[1:0], 4'd0}));
                        add_sym(b64le_pkg::KIND_CHAR, b64le_pkg::PAD_CHAR);
                        add_sym(b64le_pkg::KIND_CHAR, b64le_pkg::PAD_CHAR);
                    end
                end
                2'd1: begin
                    add_sym(b64le_pkg::KIND_CHAR, sextet({grp_bits[1:0], b[7:4]}));
                    grp_bits = {4'd0, b[3:0]};
                    grp_phase = 2'd2;
                    if (at_end) begin
                        add_sym(b64le_pkg::KIND_CHAR, sextet({b[3:0], 2'd0}));
                        add_sym(b64le_pkg::KIND_CHAR, b64le_pkg::PAD_CHAR);
                    end
                end
                default: begin
                    add_sym(b64le_pkg::KIND_CHAR, sextet({grp_bits[3:0], b[7:6]}));
                    add_sym(b64le_pkg::KIND_CHAR, sextet(b[5:0]));
                    grp_bits = 8'h00;
                    grp_phase = 2'd0;
                end
            endcase
        end
        if (at_end) begin
            add_sym(b64le_pkg::KIND_EOL, 8'h00);
            line_cnt = 6'd0;
            grp_phase = 2'd0;
            grp_bits = 8'h00;
        end
        byte_run[byte_run.size() - 1].last = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof, input int n_typed);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_byte(b, eof);
        if (n_typed == 0) begin
            foreach (byte_run[k]) pending.push_back(byte_run[k]);
        end else begin
            repeat (n_typed) begin
                pending.push_back(TYPED_SYMS[typed_pos]);
                typed_pos++;
            end
        end
        bytes_fed++;
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [b64le_pkg::CFG_IDX_W-1:0] idx, input logic v);
        drain_all();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == b64le_pkg::CFG_OUTPUT_MODE) begin
            txt_mode = v;
        end else if (idx == b64le_pkg::CFG_PREFIXED) begin
            prefix_on = v;
        end
    endtask

    always @(posedge i_clk) begin
        t_sym want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: kind %0d code %h last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending.pop_front();
                syms_checked++;
                if (m_axis_tuser !== want.kind) begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata !== want.code) begin
                    $display("%0t: code expected %h, got %h", $time, want.code, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b, got %0b", $time, want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int phase_no;
        int rand_bytes;
        int run_len;
        logic close_file;
        logic [7:0] b;
        logic new_mode;
        logic new_pfx;
        phase_no = 0;
        rand_bytes = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].op == ROW_REG) begin
                cfg_write(DIR_ROWS[r].reg_idx, DIR_ROWS[r].flag);
            end else begin
                send_byte(DIR_ROWS[r].val, DIR_ROWS[r].flag, DIR_ROWS[r].n_typed);
            end
        end

        // Each phase is one file, or a piece of one, under a fresh setting. The first
        // two phases fill whole lines in each mode; a file left open carries its line
        // and group state into the next setting.
        while (rand_bytes < RANDOM_BYTES) begin
            if (phase_no < 4) begin
                new_mode = phase_no[0];
                new_pfx = !phase_no[1];
            end else begin
                {new_mode, new_pfx} = 2'($urandom_range(0, 3));
            end
            cfg_write(b64le_pkg::CFG_OUTPUT_MODE, new_mode);
            cfg_write(b64le_pkg::CFG_PREFIXED, new_pfx);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          1'($urandom_range(0, 1)));
            end
            if (phase_no < 2) begin
                run_len = $urandom_range(48, 50);
            end else if ($urandom_range(0, 3) == 0) begin
                run_len = $urandom_range(46, 52);
            end else begin
                run_len = $urandom_range(1, 9);
            end
            if (run_len > RANDOM_BYTES - rand_bytes) run_len = RANDOM_BYTES - rand_bytes;
            close_file = (phase_no < 2) || ($urandom_range(0, 3) != 0);
            for (int k = 0; k < run_len; k++) begin
                if (rand_bytes >= CALM_AFTER) idle_on = 1'b0;
                case ($urandom_range(0, 7))
                    0: b = b64le_pkg::NEWLINE;
                    1: b = 8'h00;
                    2: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                if (txt_mode && line_cnt == b64le_pkg::LINE_BYTES_DEF - 1
                    && $urandom_range(0, 1) == 1) begin
                    b = b64le_pkg::NEWLINE;
                end
                send_byte(b, close_file && k == run_len - 1, 0);
                rand_bytes++;
            end
            phase_no++;
        end

        drain_all();
        $display("Fed %0d bytes over %0d random phases; checked %0d output symbols.",
                 bytes_fed, phase_no, syms_checked);
        $display("Both modes, both prefix settings and ignored register indexes were used.");
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
